// File: hw/rtl/double_ended_queue_macros.svh
// Assertion macros used by the deque datapath module.
// Each macro expects the clock clk and the synchronous reset rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DEQ_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that must be followed by another in the next.
`define DEQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic start;
    logic fill;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_stat_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

endpackage

// File: hw/rtl/deq_ctrl.sv
module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  deq_pkg::dp_stat_t    stat,
  output deq_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.need_read ? ST_LOOK : ST_DONE;
        end
      end
      ST_LOOK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign cmd.start = (state == ST_IDLE) && in_valid;
  assign cmd.fill  = (state == ST_LOOK);

endmodule

// File: hw/rtl/deq_dp.sv
`include "double_ended_queue_macros.svh"

module deq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::ctrl_cmd_t                  cmd,
  output deq_pkg::dp_stat_t                   stat,
  input  logic [2:0]                          operation,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0] value,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] popped_value,
  output logic [1:0]                          status,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] front_value,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] back_value,
  output logic [deq_pkg::CNT_W-1:0]           entry_count,
  output logic                                is_empty
);

  logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::DEPTH];

  deq_pkg::idx_t    front_index, front_index_next;
  deq_pkg::idx_t    back_index, back_index_next;
  deq_pkg::cnt_t    held_count, held_count_next;
  logic [deq_pkg::DATA_WIDTH-1:0] front_word, front_word_next;
  logic [deq_pkg::DATA_WIDTH-1:0] back_word, back_word_next;
  logic [deq_pkg::DATA_WIDTH-1:0] popped, popped_next;
  logic [deq_pkg::DATA_WIDTH-1:0] rd_data;
  deq_pkg::status_t status_q, status_q_next;
  logic             fill_front, fill_front_next;

  logic             wr_en;
  deq_pkg::idx_t    wr_addr;
  logic             rd_en;
  deq_pkg::idx_t    rd_addr;

  deq_pkg::op_t     op;
  logic             full;
  logic             empty;
  logic [deq_pkg::DATA_WIDTH-1:0] word;

  logic             is_push;
  logic             is_pop;
  logic             push_ok;
  logic             pop_on_empty;
  logic             empty_report;
  deq_pkg::cnt_t    count_inc;

  assign op    = deq_pkg::op_t'(operation);
  assign full  = (held_count == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign empty = (held_count == '0);
  assign word  = value[deq_pkg::DATA_WIDTH-1:0];

  assign is_push      = (op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_BACK);
  assign is_pop       = (op == deq_pkg::OP_POP_FRONT) || (op == deq_pkg::OP_POP_BACK);
  assign count_inc    = held_count + deq_pkg::cnt_t'(1);
  assign push_ok      = cmd.start && !full && is_push;
  assign pop_on_empty = cmd.start && empty && is_pop;
  assign empty_report = (status_q == deq_pkg::STATUS_EMPTY) && empty;

  // A pop that leaves words behind must fetch the new end word from the store.
  assign stat.need_read = is_pop && (held_count > deq_pkg::cnt_t'(1));

  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    held_count_next  = held_count;
    front_word_next  = front_word;
    back_word_next   = back_word;
    popped_next      = popped;
    status_q_next    = status_q;
    fill_front_next  = fill_front;
    wr_en            = 1'b0;
    wr_addr          = back_index;
    rd_en            = 1'b0;
    rd_addr          = front_index;
    if (cmd.start) begin
      popped_next   = '0;
      status_q_next = deq_pkg::STATUS_OK;
      unique case (op)
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_q_next = deq_pkg::STATUS_FULL;
          end else begin
            front_index_next = deq_pkg::idx_dec(front_index);
            wr_en            = 1'b1;
            wr_addr          = deq_pkg::idx_dec(front_index);
            held_count_next  = count_inc;
            front_word_next  = word;
            if (empty) begin
              back_word_next = word;
            end
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_q_next = deq_pkg::STATUS_FULL;
          end else begin
            back_index_next = deq_pkg::idx_inc(back_index);
            wr_en           = 1'b1;
            wr_addr         = back_index;
            held_count_next = count_inc;
            back_word_next  = word;
            if (empty) begin
              front_word_next = word;
            end
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_q_next = deq_pkg::STATUS_EMPTY;
          end else begin
            popped_next      = front_word;
            front_index_next = deq_pkg::idx_inc(front_index);
            held_count_next  = held_count - deq_pkg::cnt_t'(1);
            rd_en            = 1'b1;
            rd_addr          = deq_pkg::idx_inc(front_index);
            fill_front_next  = 1'b1;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_q_next = deq_pkg::STATUS_EMPTY;
          end else begin
            popped_next     = back_word;
            back_index_next = deq_pkg::idx_dec(back_index);
            held_count_next = held_count - deq_pkg::cnt_t'(1);
            rd_en           = 1'b1;
            rd_addr         = deq_pkg::idx_dec(deq_pkg::idx_dec(back_index));
            fill_front_next = 1'b0;
          end
        end
        default: begin
          if (empty) begin
            status_q_next = deq_pkg::STATUS_EMPTY;
          end
        end
      endcase
    end else if (cmd.fill) begin
      if (fill_front) begin
        front_word_next = rd_data;
      end else begin
        back_word_next = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      held_count  <= '0;
    end else begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      held_count  <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    front_word <= front_word_next;
    back_word  <= back_word_next;
    popped     <= popped_next;
    status_q   <= status_q_next;
    fill_front <= fill_front_next;
  end

  assign popped_value = popped;
  assign status       = status_q;
  assign front_value  = empty ? '0 : front_word;
  assign back_value   = empty ? '0 : back_word;
  assign entry_count  = held_count;
  assign is_empty     = empty;

  `DEQ_ASSERT(a_count_bound, held_count <= deq_pkg::cnt_t'(deq_pkg::DEPTH), "count beyond depth")
  `DEQ_ASSERT_NEXT(a_push_grows, push_ok, held_count == $past(count_inc), "push added no word")
  `DEQ_ASSERT_NEXT(a_pop_empty_status, pop_on_empty, empty_report, "pop on empty misreported")
  `DEQ_ASSERT(a_fill_nonempty, !cmd.fill || (held_count != '0), "store fetch with no words held")

endmodule

// File: hw/rtl/double_ended_queue.sv
// Channel  Handshake              Beat fields
// input    in_valid / in_stall    operation, value
// output   out_valid / out_stall  popped_value, status, front_value, back_value,
//                                 entry_count, is_empty
//
// One item is in the block at a time, and each input beat gives one output beat.
// A push, a query or a pop that leaves the deque empty gives its result in the cycle
// after it is accepted; a pop that leaves words behind first passes through a fetch
// state, as its new end word comes from the registered store read port. The next
// beat is taken once the result has left. A stalled result holds the input stalled.
// Reset clears the pointers and the count; the store itself is not cleared.
module double_ended_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          operation,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] popped_value,
  output logic [1:0]                          status,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] front_value,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] back_value,
  output logic [deq_pkg::CNT_W-1:0]           entry_count,
  output logic                                is_empty
);

  deq_pkg::ctrl_cmd_t cmd;
  deq_pkg::dp_stat_t  stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .value        (value),
    .popped_value (popped_value),
    .status       (status),
    .front_value  (front_value),
    .back_value   (back_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

endmodule
